### src/ship_rrip_stream_aware_replacement_macros.svh
// Assertion macros used by the replacement policy top level.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef SHIP_RRIP_STREAM_AWARE_REPLACEMENT_MACROS_SVH
`define SHIP_RRIP_STREAM_AWARE_REPLACEMENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHIPRR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("shiprr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SHIPRR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("shiprr: next-cycle check failed");

`endif

### src/shiprr_pkg.sv
// Shared types and constants of the stream-aware RRIP replacement block.
// Depends on nothing; used by the row update logic and the top level.
package shiprr_pkg;

    localparam int NUM_SETS       = 2048;
    localparam int NUM_WAYS       = 16;
    localparam int SIGNATURE_BITS = 4;

    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int NUM_SIGS = 1 << SIGNATURE_BITS;
    localparam int AGE_W    = 2;
    localparam int CTR_W    = 2;
    localparam int BLK_W    = 32;
    localparam int PC_W     = 8;
    localparam int WAYF_W   = 4;

    localparam logic [AGE_W-1:0] AGE_MAX = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

    // Operation codes carried in the input tuser.
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE
    } state_t;

    // Everything one set keeps, held as one memory row.
    typedef struct packed {
        logic [BLK_W-1:0]                           prev_block;
        logic                                       stream;
        logic [NUM_SIGS-1:0][CTR_W-1:0]             ctr;
        logic [NUM_WAYS-1:0][SIGNATURE_BITS-1:0]    sig;
        logic [NUM_WAYS-1:0][AGE_W-1:0]             age;
    } row_t;

    // One accepted item, less the set index that addresses the row.
    typedef struct packed {
        logic              op;
        logic [WAYF_W-1:0] way;
        logic              hit;
        logic [BLK_W-1:0]  blk;
        logic [PC_W-1:0]   pc;
    } item_t;

    localparam row_t ROW_RESET = '{
        prev_block: '0,
        stream:     1'b0,
        ctr:        {NUM_SIGS{2'b01}},
        sig:        '0,
        age:        '1
    };

endpackage

### src/shiprr_row_ram.sv
// Generic single-port-write, registered-read RAM holding the per-set rows.
// Depends on nothing.
module shiprr_row_ram #(
    parameter int DEPTH  = 2048,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/shiprr_row_update.sv
// Combinational modify step: ages the set for a victim request, or applies
// a hit or miss update to the row. Depends on shiprr_pkg.
module shiprr_row_update
    import shiprr_pkg::*;
(
    input  row_t              row_in,
    input  item_t             item,
    output row_t              row_out,
    output logic [WAYF_W-1:0] victim
);

    logic [AGE_W-1:0]          oldest;
    logic [AGE_W-1:0]          add;
    logic [BLK_W-1:0]          delta;
    logic                      stream_new;
    logic [BLK_W-1:0]          sig_full;
    logic [SIGNATURE_BITS-1:0] sig_new;
    logic [SIGNATURE_BITS-1:0] sig_old;
    logic [CTR_W-1:0]          ctr_old;
    logic [CTR_W-1:0]          ctr_new;
    logic [AGE_W-1:0]          ins_age;
    logic [WAY_W-1:0]          widx;
    logic                      way_ok;

    always_comb begin
        row_out = row_in;
        victim  = '0;

        // Oldest age in the set, found bit by bit across the ways.
        oldest[1] = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            oldest[1] = oldest[1] | row_in.age[w][1];
        end
        oldest[0] = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            oldest[0] = oldest[0] | ((row_in.age[w][1] == oldest[1]) & row_in.age[w][0]);
        end
        add = AGE_MAX - oldest;

        // Streaming detector on the block address stride.
        delta = item.blk - row_in.prev_block;
        stream_new = row_in.stream;
        if (row_in.prev_block != '0) begin
            if (delta == BLK_W'(1) || delta == '1) begin
                stream_new = 1'b1;
            end else if (delta != '0) begin
                stream_new = 1'b0;
            end
        end

        // Signature of this access, and the counters involved.
        sig_full = BLK_W'(item.pc) ^ BLK_W'(item.pc >> 4) ^ (item.blk >> 2);
        sig_new  = sig_full[SIGNATURE_BITS-1:0];
        widx     = item.way[WAY_W-1:0];
        way_ok   = (32'(item.way) < NUM_WAYS);
        sig_old  = row_in.sig[widx];
        ctr_old  = row_in.ctr[sig_old];
        ctr_new  = row_in.ctr[sig_new];

        if (stream_new) begin
            ins_age = AGE_MAX;
        end else if (ctr_new >= 2'd2) begin
            ins_age = 2'd0;
        end else if (ctr_new == 2'd1) begin
            ins_age = 2'd2;
        end else begin
            ins_age = AGE_MAX;
        end

        if (item.op == OP_VICTIM) begin
            // Age the set so that at least one way reaches the maximum,
            // then take the lowest such way.
            for (int w = 0; w < NUM_WAYS; w++) begin
                row_out.age[w] = row_in.age[w] + add;
            end
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (row_out.age[w] == AGE_MAX) begin
                    victim = WAYF_W'(w);
                end
            end
        end else begin
            row_out.stream     = stream_new;
            row_out.prev_block = item.blk;
            if (way_ok) begin
                if (item.hit) begin
                    // Promote the line and strengthen its signature.
                    row_out.age[widx] = '0;
                    if (ctr_old != CTR_MAX) begin
                        row_out.ctr[sig_old] = ctr_old + 2'd1;
                    end
                end else begin
                    // Fill: retag the line, weaken the evicted signature.
                    row_out.sig[widx] = sig_new;
                    row_out.age[widx] = ins_age;
                    if (ctr_old != '0) begin
                        row_out.ctr[sig_old] = ctr_old - 2'd1;
                    end
                end
            end
        end
    end

endmodule

### src/ship_rrip_stream_aware_replacement.sv
// Top level of the stream-aware RRIP replacement block: handshakes, the
// row memory, the clearing pass and the read-modify-write sequencer.
// Depends on shiprr_pkg, shiprr_row_ram, shiprr_row_update and the macros.
//
// Channel  Dir  Ports                                Content
// s_       in   s_tvalid s_tready s_tdata s_tuser    request item
// m_       out  m_tvalid m_tready m_tdata            victim way item
//
// Each item's row is read from the single row memory in the cycle the item is
// accepted and written back in the next; no item is accepted meanwhile.
// After reset a clearing pass writes every row once, during which no item
// is accepted.
// A result waits in the output register; a new item is accepted once that
// register is empty or is being emptied in the same cycle.
`include "ship_rrip_stream_aware_replacement_macros.svh"

module ship_rrip_stream_aware_replacement
    import shiprr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: set_index[10:0], way[14:11],
    // block_address[46:15], pc_low[54:47], zero[55]
    input  logic [55:0] s_tdata,
    // s_tuser, lowest bit up: operation[0], hit[1]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: victim_way[3:0], zero[7:4]
    output logic [7:0]  m_tdata
);

    state_t            state_reg, state_next;
    logic [SET_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0]  set_reg;
    item_t             item_reg;
    logic              m_valid_reg, m_valid_next;
    logic [WAYF_W-1:0] victim_reg;

    logic              accept;
    logic              ram_we;
    logic [SET_W-1:0]  ram_waddr;
    row_t              ram_wdata;
    row_t              row_rd;
    row_t              row_mod;
    logic [WAYF_W-1:0] victim_mod;

    // Row memory.
    shiprr_row_ram #(
        .DEPTH (NUM_SETS),
        .WIDTH ($bits(row_t))
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s_tdata[SET_W-1:0]),
        .rdata (row_rd)
    );

    // Modify step on the row just read.
    shiprr_row_update u_upd (
        .row_in  (row_rd),
        .item    (item_reg),
        .row_out (row_mod),
        .victim  (victim_mod)
    );

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item capture and result register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg      <= s_tdata[10:0];
            item_reg.op  <= s_tuser[0];
            item_reg.hit <= s_tuser[1];
            item_reg.way <= s_tdata[14:11];
            item_reg.blk <= s_tdata[46:15];
            item_reg.pc  <= s_tdata[54:47];
        end
        if (state_reg == ST_WRITE) begin
            victim_reg <= (item_reg.op == OP_VICTIM) ? victim_mod : '0;
        end
    end

    // Sequencer: clearing pass, then read on accept and write back.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = set_reg;
        ram_wdata    = row_mod;
        m_valid_next = m_valid_reg & ~m_tready;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = ROW_RESET;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = ~m_valid_reg | m_tready;
                if (s_tvalid && s_tready) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ram_we       = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - WAYF_W){1'b0}}, victim_reg};

    // No item is taken while the memory is being cleared.
    `SHIPRR_ASSERT_SAME(a_no_accept_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_tready)
    // An accepted item always goes to its write-back cycle.
    `SHIPRR_ASSERT_NEXT(a_accept_write, aclk, aresetn, accept, state_reg == ST_WRITE)
    // The write-back cycle always leaves a result waiting.
    `SHIPRR_ASSERT_NEXT(a_write_result, aclk, aresetn, state_reg == ST_WRITE, m_tvalid)
    // A stalled result blocks the next item.
    `SHIPRR_ASSERT_SAME(a_stall_block, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    // Updates report way zero.
    `SHIPRR_ASSERT_NEXT(a_update_zero, aclk, aresetn,
        state_reg == ST_WRITE && item_reg.op == OP_UPDATE, m_tdata == 8'd0)

endmodule

### tb/tb_ship_rrip_stream_aware_replacement.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stream-aware RRIP replacement block.
// It keeps its own copy of the per-set ages, signatures, counters and stream
// detectors, and checks every victim item; it depends on shiprr_pkg and the top level.
module tb_ship_rrip_stream_aware_replacement;
    import shiprr_pkg::*;

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 175;

    // One request as the sender sees it.
    typedef struct {
        logic                op;
        logic [SET_W-1:0]    set_idx;
        logic [WAYF_W-1:0]   way;
        logic                hit;
        logic [BLK_W-1:0]    blk;
        logic [PC_W-1:0]     pc;
    } access_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // Shadow copy of the replacement state.
    logic [AGE_W-1:0]          age_mem      [NUM_SETS*NUM_WAYS];
    logic [SIGNATURE_BITS-1:0] sig_mem      [NUM_SETS*NUM_WAYS];
    logic [CTR_W-1:0]          ctr_mem      [NUM_SETS*NUM_SIGS];
    logic                      stream_mem   [NUM_SETS];
    logic [BLK_W-1:0]          last_blk_mem [NUM_SETS];

    logic [WAYF_W-1:0] expected_victims [$];
    logic [WAYF_W-1:0] last_victim;
    logic [SET_W-1:0]  hot_sets [4];

    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  hold_start = 1'b0;

    ship_rrip_stream_aware_replacement dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one accepted item to the shadow state and returns the victim it yields.
    function automatic logic [WAYF_W-1:0] apply_access(input access_t a);
        int unsigned set_base, line, old_c;
        logic [AGE_W-1:0] oldest, lift, ins_age;
        logic [CTR_W-1:0] new_count;
        logic [BLK_W-1:0] prior, stride;
        logic [SIGNATURE_BITS-1:0] new_sig;
        logic [WAYF_W-1:0] pick;
        set_base = int'(a.set_idx) * NUM_WAYS;
        pick = '0;
        if (a.op == OP_VICTIM) begin
            // Age the set just enough for some way to reach the maximum.
            oldest = '0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (age_mem[set_base + w] > oldest) oldest = age_mem[set_base + w];
            end
            if (oldest < AGE_MAX) begin
                lift = AGE_MAX - oldest;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    age_mem[set_base + w] = age_mem[set_base + w] + lift;
                end
            end
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (age_mem[set_base + w] == AGE_MAX) pick = WAYF_W'(w);
            end
            last_victim = pick;
        end else begin
            // Stream detector follows the stride from the previous block.
            prior = last_blk_mem[a.set_idx];
            stride = a.blk - prior;
            new_sig = SIGNATURE_BITS'(a.pc ^ (a.pc >> 4) ^ (a.blk >> 2));
            if (prior != '0 && (stride == 32'd1 || stride == '1)) begin
                stream_mem[a.set_idx] = 1'b1;
            end else if (prior != '0 && stride != '0) begin
                stream_mem[a.set_idx] = 1'b0;
            end
            last_blk_mem[a.set_idx] = a.blk;
            if (int'(a.way) < NUM_WAYS) begin
                line = set_base + int'(a.way);
                old_c = int'(a.set_idx) * NUM_SIGS + int'(sig_mem[line]);
                if (a.hit) begin
                    age_mem[line] = '0;
                    if (ctr_mem[old_c] < CTR_MAX) ctr_mem[old_c] = ctr_mem[old_c] + 1'b1;
                end else begin
                    if (stream_mem[a.set_idx]) begin
                        ins_age = AGE_MAX;
                    end else begin
                        new_count = ctr_mem[int'(a.set_idx) * NUM_SIGS + int'(new_sig)];
                        ins_age = (new_count >= 2) ? 2'd0 : ((new_count == 1) ? 2'd2 : 2'd3);
                    end
                    sig_mem[line] = new_sig;
                    age_mem[line] = ins_age;
                    if (ctr_mem[old_c] > 0) ctr_mem[old_c] = ctr_mem[old_c] - 1'b1;
                end
            end
        end
        return pick;
    endfunction

    function automatic access_t mk(input logic op, input int set_idx, input int way,
                                   input logic hit, input logic [BLK_W-1:0] blk,
                                   input logic [PC_W-1:0] pc);
        access_t a;
        a.op = op;
        a.set_idx = SET_W'(set_idx);
        a.way = WAYF_W'(way);
        a.hit = hit;
        a.blk = blk;
        a.pc = pc;
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Offers one item, waits for it to be taken and records its expected victim.
    // Valid is only lowered inside an idle gap, so back-to-back items keep it high.
    task automatic send_item(input access_t a);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, a.pc, a.blk, a.way, a.set_idx};
        s_tuser  <= {a.hit, a.op};
        do @(posedge aclk); while (!s_tready);
        expected_victims.push_back(apply_access(a));
    endtask

    // A well-formed access to one set: a hit, or a victim request and its fill.
    task automatic send_cache_access(input logic [SET_W-1:0] s);
        logic [BLK_W-1:0] blk;
        logic [PC_W-1:0] pc;
        int roll;
        int fill_way;
        roll = $urandom_range(0, 99);
        if (roll < 25) blk = last_blk_mem[s] + 1'b1;
        else if (roll < 40) blk = last_blk_mem[s] - 1'b1;
        else if (roll < 50) blk = last_blk_mem[s];
        else if (roll < 55) blk = ($urandom_range(0, 1) != 0) ? '0 : '1;
        else blk = $urandom;
        pc = ($urandom_range(0, 99) < 70) ? PC_W'($urandom_range(0, 3)) : PC_W'($urandom);
        if ($urandom_range(0, 99) < 40) begin
            send_item(mk(OP_UPDATE, s, $urandom_range(0, NUM_WAYS - 1), 1'b1, blk, pc));
        end else begin
            send_item(mk(OP_VICTIM, s, $urandom_range(0, NUM_WAYS - 1),
                         1'($urandom_range(0, 1)), blk, pc));
            fill_way = ($urandom_range(0, 99) < 90) ? int'(last_victim)
                                                     : $urandom_range(0, NUM_WAYS - 1);
            send_item(mk(OP_UPDATE, s, fill_way, 1'b0, blk, pc));
        end
    endtask

    // Fresh sets, extremes of every field, unused fields on victim requests.
    task automatic test_basic_operations();
        send_item(mk(OP_VICTIM, 0, 15, 1'b1, 32'hFFFF_FFFF, 8'hFF));
        send_item(mk(OP_UPDATE, 0, 0, 1'b0, 32'h0000_0100, 8'h00));
        send_item(mk(OP_VICTIM, 0, 0, 1'b0, 32'h0000_0000, 8'h00));
        send_item(mk(OP_UPDATE, NUM_SETS - 1, 15, 1'b1, 32'hFFFF_FFFF, 8'hFF));
        send_item(mk(OP_VICTIM, NUM_SETS - 1, 7, 1'b1, 32'h1234_5678, 8'h3C));
        send_item(mk(OP_UPDATE, NUM_SETS - 1, 15, 1'b0, 32'h0000_0000, 8'h5A));
        send_item(mk(OP_VICTIM, NUM_SETS - 1, 0, 1'b0, 32'h0000_0000, 8'h00));
    endtask

    // Strides of +1, -1, zero and other, including the wrap through zero.
    task automatic test_stream_detector();
        send_item(mk(OP_UPDATE, 33, 1, 1'b0, 32'h0000_1000, 8'h21));
        send_item(mk(OP_UPDATE, 33, 2, 1'b0, 32'h0000_1001, 8'h21));
        send_item(mk(OP_UPDATE, 33, 3, 1'b0, 32'h0000_1000, 8'h21));
        send_item(mk(OP_UPDATE, 33, 4, 1'b0, 32'h0000_1000, 8'h21));
        send_item(mk(OP_UPDATE, 33, 5, 1'b0, 32'h0000_2000, 8'h21));
        send_item(mk(OP_VICTIM, 33, 0, 1'b0, 32'h0000_2000, 8'h21));
        send_item(mk(OP_UPDATE, 34, 6, 1'b1, 32'hFFFF_FFFF, 8'h80));
        send_item(mk(OP_UPDATE, 34, 6, 1'b0, 32'h0000_0000, 8'h80));
        send_item(mk(OP_VICTIM, 34, 0, 1'b0, 32'h0000_0000, 8'h80));
    endtask

    // Repeated hits saturate a counter; the misses that follow weaken it again.
    task automatic test_counter_saturation();
        send_item(mk(OP_UPDATE, 77, 0, 1'b0, 32'h0000_0040, 8'h11));
        for (int i = 0; i < 4; i++) send_item(mk(OP_UPDATE, 77, 0, 1'b1, 32'h0000_0080, 8'h11));
        send_item(mk(OP_VICTIM, 77, 0, 1'b0, 32'h0000_0080, 8'h11));
        send_item(mk(OP_UPDATE, 77, 0, 1'b0, 32'h0000_0300, 8'h00));
        send_item(mk(OP_UPDATE, 77, 0, 1'b0, 32'h0000_0500, 8'h00));
    endtask

    // Mostly well-formed traffic on a few busy sets, with some noise anywhere.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int sent_before;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        hot_sets[0] = '0;
        hot_sets[1] = SET_W'(NUM_SETS - 1);
        hot_sets[2] = SET_W'($urandom_range(0, NUM_SETS - 1));
        hot_sets[3] = SET_W'($urandom_range(0, NUM_SETS - 1));
        sent_before = 0;
        while (sent_before < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(mk(1'($urandom_range(0, 1)), $urandom_range(0, NUM_SETS - 1),
                             $urandom_range(0, NUM_WAYS - 1), 1'($urandom_range(0, 1)),
                             $urandom, PC_W'($urandom)));
                sent_before++;
            end else begin
                send_cache_access(hot_sets[$urandom_range(0, 3)]);
                sent_before += 2;
            end
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_start = 1'b1;
        for (int i = 0; i < 20; i++) send_cache_access(hot_sets[i % 4]);
    endtask

    // Receiver: random stalls, or a long hold when asked for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_start) begin
            hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compares each victim item with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_victims.size() == 0) begin
                report_mismatch($sformatf("unexpected item, victim_way %0d", m_tdata[3:0]));
            end else if (m_tdata[3:0] !== expected_victims[0]) begin
                report_mismatch($sformatf("victim_way %0d, expected %0d",
                                          m_tdata[3:0], expected_victims[0]));
                void'(expected_victims.pop_front());
            end else begin
                void'(expected_victims.pop_front());
            end
        end
    end

    // Ends the run if no item moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_ship_rrip_stream_aware_replacement: done, errors");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        for (int i = 0; i < NUM_SETS * NUM_WAYS; i++) begin
            age_mem[i] = AGE_MAX;
            sig_mem[i] = '0;
        end
        for (int i = 0; i < NUM_SETS * NUM_SIGS; i++) ctr_mem[i] = 2'd1;
        for (int i = 0; i < NUM_SETS; i++) begin
            stream_mem[i] = 1'b0;
            last_blk_mem[i] = '0;
        end
        last_victim = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_operations();
        test_stream_detector();
        test_counter_saturation();
        test_random_traffic(0, 0);
        test_random_traffic(46, 0);
        test_random_traffic(0, 46);
        test_random_traffic(20, 20);
        test_output_backpressure();
        s_tvalid <= 1'b0;

        // Let the last victim items drain, then allow for the pipeline.
        wait (expected_victims.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_ship_rrip_stream_aware_replacement: done, clean");
        end else begin
            $display("tb_ship_rrip_stream_aware_replacement: done, errors");
        end
        $finish;
    end

endmodule
